FILE: hdl/tesa_pkg.sv
// tesa_pkg: shared types and constants for the two-ended stack allocator.
// Holds function, status and placement codes and the step record passed between stages.
// No dependencies.
package tesa_pkg;

   localparam int unsigned OFFS_W       = 32;
   // alignments must be powers of two, padding is done by masking
   localparam int unsigned PERM_ALIGN   = 64;
   localparam int unsigned TEMP_ALIGN   = 8;
   localparam int unsigned HEADER_BYTES = 16;
   localparam logic [OFFS_W-1:0] HUNK_RESET = 32'd67108864;

   typedef enum logic [2:0] {
      FN_ALLOC_PERM = 3'd0,
      FN_ALLOC_TEMP = 3'd1,
      FN_FREE_TEMP  = 3'd2,
      FN_CLEAR_TEMP = 3'd3,
      FN_SET_MARK   = 3'd4,
      FN_CLEAR_MARK = 3'd5,
      FN_CLEAR_ALL  = 3'd6,
      FN_NOP        = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_ROOM   = 2'd1,
      ST_ZERO_SIZE = 2'd2,
      ST_NOT_LAST  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PL_EITHER     = 2'd0,
      PL_LOW        = 2'd1,
      PL_HIGH       = 2'd2,
      PL_EITHER_ALT = 2'd3
   } place_type;

   // result of one step plus a snapshot of the offsets after it
   typedef struct packed {
      status_type        status;
      logic [OFFS_W-1:0] grant_offset;
      logic [OFFS_W-1:0] granted_size;
      logic [OFFS_W-1:0] low_perm;
      logic [OFFS_W-1:0] low_temp;
      logic [OFFS_W-1:0] high_perm;
      logic [OFFS_W-1:0] high_temp;
      logic              mark_set;
      logic              perm_on_low;
   } step_type;

endpackage

FILE: hdl/tesa_core.sv
// tesa_core: offset registers of both ends and the combinational step logic.
// Also holds the region size register. Depends on tesa_pkg.
module tesa_core
   import tesa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wen,
   input  logic [OFFS_W-1:0] csr_wdata,
   input  logic              fire,
   input  func_type          func,
   input  logic [OFFS_W-1:0] req_size,
   input  place_type         placement,
   input  logic [OFFS_W-1:0] block_offset,
   input  logic [OFFS_W-1:0] block_size,
   output step_type          step,
   output logic [OFFS_W-1:0] hunk_size
);

   localparam logic [32:0] PMASK = 33'(PERM_ALIGN - 1);
   localparam logic [32:0] TMASK = 33'(TEMP_ALIGN - 1);

   logic [OFFS_W-1:0] hunk_ff;
   logic [OFFS_W-1:0] lm_ff, lp_ff, lt_ff, lhw_ff, hm_ff, hp_ff, ht_ff, hhw_ff;
   logic [OFFS_W-1:0] lm_in, lp_in, lt_in, lhw_in, hm_in, hp_in, ht_in, hhw_in;
   logic              pbl_ff, pbl_in;

   logic              tend_clear, slack_gt, swap_ok, do_swap;
   logic [33:0]       slack_low, slack_high;
   logic [32:0]       perm_sz, lp_sum, hp_sum;
   logic [33:0]       temp_sz, perm_need, need_th, need_tl, lt_sum, ht_sum;
   logic              perm_fit, temp_fit;
   logic [OFFS_W-1:0] t_cur, pt_cur, in_use, hdr;
   logic [34:0]       want;
   logic              free_ok;

   always_comb begin
      tend_clear = pbl_ff ? (ht_ff == hp_ff) : (lt_ff == lp_ff);
      slack_low  = {2'b00, lhw_ff} - {2'b00, lp_ff};
      slack_high = {2'b00, hhw_ff} - {2'b00, hp_ff};
      // temp end must beat the permanent end on high-water slack
      slack_gt   = pbl_ff ? ($signed(slack_high) > $signed(slack_low))
                          : ($signed(slack_low) > $signed(slack_high));
      swap_ok    = tend_clear && slack_gt;

      perm_sz    = ({1'b0, req_size} + PMASK) & ~PMASK;
      temp_sz    = {1'b0, (({1'b0, req_size} + TMASK) & ~TMASK)} + 34'(HEADER_BYTES);
      perm_need  = {2'b00, lt_ff} + {2'b00, ht_ff} + {1'b0, perm_sz};
      perm_fit   = perm_need <= {2'b00, hunk_ff};
      // both possible bank orders, the swap only selects
      need_th    = {2'b00, ht_ff} + {2'b00, lp_ff} + temp_sz;
      need_tl    = {2'b00, lt_ff} + {2'b00, hp_ff} + temp_sz;
      lp_sum     = {1'b0, lp_ff} + perm_sz;
      hp_sum     = {1'b0, hp_ff} + perm_sz;
      lt_sum     = {2'b00, lt_ff} + temp_sz;
      ht_sum     = {2'b00, ht_ff} + temp_sz;

      t_cur      = pbl_ff ? ht_ff : lt_ff;
      pt_cur     = pbl_ff ? hp_ff : lp_ff;
      in_use     = t_cur - pt_cur;
      want       = pbl_ff ? ({3'b000, hunk_ff} - {3'b000, t_cur} + 35'(HEADER_BYTES))
                          : ({3'b000, t_cur} - {3'b000, block_size} + 35'(HEADER_BYTES));
      free_ok    = (t_cur >= pt_cur) && (block_size <= in_use)
                   && (want == {3'b000, block_offset});

      do_swap  = 1'b0;
      temp_fit = 1'b0;
      hdr      = '0;
      lm_in = lm_ff;  lp_in = lp_ff;  lt_in = lt_ff;  lhw_in = lhw_ff;
      hm_in = hm_ff;  hp_in = hp_ff;  ht_in = ht_ff;  hhw_in = hhw_ff;
      step.status       = ST_OK;
      step.grant_offset = '0;
      step.granted_size = '0;

      unique case (func)
         FN_ALLOC_PERM: begin
            if (req_size == '0) begin
               step.status = ST_ZERO_SIZE;
            end else begin
               do_swap = swap_ok && ((placement == PL_EITHER) || (placement == PL_EITHER_ALT)
                         || ((placement == PL_LOW) && !pbl_ff)
                         || ((placement == PL_HIGH) && pbl_ff));
               if (!perm_fit) begin
                  step.status = ST_NO_ROOM;
               end else if (pbl_ff ^ do_swap) begin
                  step.grant_offset = lp_ff;
                  lp_in = lp_sum[OFFS_W-1:0];
                  lt_in = lp_sum[OFFS_W-1:0];
                  step.granted_size = perm_sz[OFFS_W-1:0];
               end else begin
                  hp_in = hp_sum[OFFS_W-1:0];
                  ht_in = hp_sum[OFFS_W-1:0];
                  step.grant_offset = hunk_ff - hp_sum[OFFS_W-1:0];
                  step.granted_size = perm_sz[OFFS_W-1:0];
               end
            end
         end
         FN_ALLOC_TEMP: begin
            do_swap  = swap_ok;
            temp_fit = (pbl_ff ^ do_swap) ? (need_th <= {2'b00, hunk_ff})
                                          : (need_tl <= {2'b00, hunk_ff});
            if (!temp_fit) begin
               step.status = ST_NO_ROOM;
            end else if (pbl_ff ^ do_swap) begin
               ht_in = ht_sum[OFFS_W-1:0];
               hdr   = hunk_ff - ht_sum[OFFS_W-1:0];
               if (ht_sum[OFFS_W-1:0] > hhw_ff) hhw_in = ht_sum[OFFS_W-1:0];
               step.grant_offset = hdr + OFFS_W'(HEADER_BYTES);
               step.granted_size = temp_sz[OFFS_W-1:0];
            end else begin
               hdr   = lt_ff;
               lt_in = lt_sum[OFFS_W-1:0];
               if (lt_sum[OFFS_W-1:0] > lhw_ff) lhw_in = lt_sum[OFFS_W-1:0];
               step.grant_offset = hdr + OFFS_W'(HEADER_BYTES);
               step.granted_size = temp_sz[OFFS_W-1:0];
            end
         end
         FN_FREE_TEMP: begin
            if (!free_ok) begin
               step.status = ST_NOT_LAST;
            end else if (pbl_ff) begin
               ht_in = ht_ff - block_size;
            end else begin
               lt_in = lt_ff - block_size;
            end
         end
         FN_CLEAR_TEMP: begin
            if (pbl_ff) ht_in = hp_ff;
            else        lt_in = lp_ff;
         end
         FN_SET_MARK: begin
            lm_in = lp_ff;
            hm_in = hp_ff;
         end
         FN_CLEAR_MARK: begin
            lp_in = lm_ff;  lt_in = lm_ff;
            hp_in = hm_ff;  ht_in = hm_ff;
         end
         FN_CLEAR_ALL: begin
            lm_in = '0;  lp_in = '0;  lt_in = '0;  lhw_in = '0;
            hm_in = '0;  hp_in = '0;  ht_in = '0;  hhw_in = '0;
         end
         FN_NOP: begin
         end
      endcase

      pbl_in = (func == FN_CLEAR_ALL) ? 1'b1 : (pbl_ff ^ do_swap);

      step.low_perm    = lp_in;
      step.low_temp    = lt_in;
      step.high_perm   = hp_in;
      step.high_temp   = ht_in;
      step.mark_set    = (lm_in != '0) || (hm_in != '0);
      step.perm_on_low = pbl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunk_ff <= HUNK_RESET;
      end else if (csr_wen) begin
         hunk_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lm_ff  <= '0;  lp_ff <= '0;  lt_ff <= '0;  lhw_ff <= '0;
         hm_ff  <= '0;  hp_ff <= '0;  ht_ff <= '0;  hhw_ff <= '0;
         pbl_ff <= 1'b1;
      end else if (fire) begin
         lm_ff  <= lm_in;  lp_ff <= lp_in;  lt_ff <= lt_in;  lhw_ff <= lhw_in;
         hm_ff  <= hm_in;  hp_ff <= hp_in;  ht_ff <= ht_in;  hhw_ff <= hhw_in;
         pbl_ff <= pbl_in;
      end
   end

   assign hunk_size = hunk_ff;

endmodule

FILE: hdl/tesa_report.sv
// tesa_report: derives bytes remaining and the temp-clear flag from a step snapshot.
// Depends on tesa_pkg.
module tesa_report
   import tesa_pkg::*;
(
   input  step_type          step,
   input  logic [OFFS_W-1:0] hunk_size,
   output logic [OFFS_W-1:0] bytes_left,
   output logic              temp_clear
);

   logic [OFFS_W-1:0] lo_top, hi_top;
   logic [OFFS_W:0]   used;

   always_comb begin
      lo_top = (step.low_perm > step.low_temp) ? step.low_perm : step.low_temp;
      hi_top = (step.high_perm > step.high_temp) ? step.high_perm : step.high_temp;
      used   = {1'b0, lo_top} + {1'b0, hi_top};
      // saturate when the region was shrunk below its usage
      bytes_left = (used > {1'b0, hunk_size}) ? '0 : (hunk_size - used[OFFS_W-1:0]);
      temp_clear = step.perm_on_low ? (step.high_temp == step.high_perm)
                                    : (step.low_temp == step.low_perm);
   end

endmodule

FILE: hdl/two_ended_stack_allocator.sv
// two_ended_stack_allocator: a request goes through the input, step result and output registers to a valid result.
// Throughput is one item per cycle while the response channel does not stall; the offset registers
// are read and updated once per item as it fires, so each item sees the state the previous one left.
// Synchronous active-high reset clears all offsets and marks, selects the low end for
// permanent blocks and loads a region size of 64 MiB; pipeline stages come up empty.
// Depends on tesa_pkg, tesa_core and tesa_report.
module two_ended_stack_allocator
   import tesa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [103:0]       req_tdata,  // req_size[31:0], placement[33:32],
                                          // block_offset[65:34], block_size[97:66], zero pad
   input  logic [2:0]         req_tuser,  // func[2:0]
   // response channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [103:0]       rsp_tdata,  // grant_offset[31:0], granted_size[63:32],
                                          // bytes_left[95:64], temp_clear[96], mark_set[97],
                                          // perm_on_low[98], zero pad
   output logic [1:0]         rsp_tuser,  // status[1:0]
   // configuration
   input  logic               csr_wen,
   input  logic [OFFS_W-1:0]  csr_wdata
);

   logic              s0_v_ff, s1_v_ff, s2_v_ff;
   func_type          func_ff;
   logic [OFFS_W-1:0] req_size_ff, block_offset_ff, block_size_ff;
   place_type         placement_ff;
   step_type          s1_step_ff;
   step_type          step_in;
   logic [OFFS_W-1:0] hunk_size;
   logic [OFFS_W-1:0] bytes_left_in;
   logic              temp_clear_in;
   logic [103:0]      rsp_tdata_ff;
   status_type        rsp_status_ff;
   logic              s2_take, s1_take, fire;

   assign s2_take    = !s2_v_ff || rsp_tready;
   assign s1_take    = !s1_v_ff || s2_take;
   assign fire       = s0_v_ff && s1_take;
   assign req_tready = !s0_v_ff || s1_take;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (req_tready) begin
         s0_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         func_ff         <= func_type'(req_tuser);
         req_size_ff     <= req_tdata[31:0];
         placement_ff    <= place_type'(req_tdata[33:32]);
         block_offset_ff <= req_tdata[65:34];
         block_size_ff   <= req_tdata[97:66];
      end
   end

   tesa_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .fire         (fire),
      .func         (func_ff),
      .req_size     (req_size_ff),
      .placement    (placement_ff),
      .block_offset (block_offset_ff),
      .block_size   (block_size_ff),
      .step         (step_in),
      .hunk_size    (hunk_size)
   );

   // step result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_take) begin
         s1_v_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) s1_step_ff <= step_in;
   end

   tesa_report u_report (
      .step       (s1_step_ff),
      .hunk_size  (hunk_size),
      .bytes_left (bytes_left_in),
      .temp_clear (temp_clear_in)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_take) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_take && s1_v_ff) begin
         rsp_status_ff <= s1_step_ff.status;
         rsp_tdata_ff  <= {5'b00000, s1_step_ff.perm_on_low, s1_step_ff.mark_set,
                           temp_clear_in, bytes_left_in, s1_step_ff.granted_size,
                           s1_step_ff.grant_offset};
      end
   end

   assign rsp_tvalid = s2_v_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_status_ff;

   // permanent end never holds temp blocks above its permanent top
   a_perm_end_flat: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> (s1_step_ff.perm_on_low ? (s1_step_ff.low_temp == s1_step_ff.low_perm)
                                          : (s1_step_ff.high_temp == s1_step_ff.high_perm)))
      else $error("permanent end temp top differs from its permanent top");

   // temp end stack never drops below its permanent top
   a_temp_end_order: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> (s1_step_ff.perm_on_low ? (s1_step_ff.high_temp >= s1_step_ff.high_perm)
                                          : (s1_step_ff.low_temp >= s1_step_ff.low_perm)))
      else $error("temp end top below its permanent top");

   // a refused step grants nothing
   a_refused_no_grant: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && (s1_step_ff.status != ST_OK)) |->
         ((s1_step_ff.grant_offset == '0) && (s1_step_ff.granted_size == '0)))
      else $error("grant reported on a refused step");

   // pipeline comes up empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !s1_v_ff))
      else $error("pipeline not empty after reset");

endmodule

FILE: tb/sv/tb_two_ended_stack_allocator.sv
// tb_two_ended_stack_allocator: self-checking testbench for the two-ended stack allocator.
// Drives request transfers, predicts every response from a shadow of both region ends,
// and compares responses in order. Depends on tesa_pkg and two_ended_stack_allocator.
module tb_two_ended_stack_allocator;
   import tesa_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 150;
   localparam int LOW_SIDE    = 0;
   localparam int HIGH_SIDE   = 1;

   typedef struct {
      status_type status;
      bit [31:0]  grant_offset;
      bit [31:0]  granted_size;
      bit [31:0]  bytes_left;
      bit         temp_clear;
      bit         mark_set;
      bit         perm_on_low;
   } hunk_outcome_type;

   typedef struct {
      bit [31:0] offs;
      bit [31:0] bytes;
   } temp_block_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [103:0]  req_tdata = '0;
   logic [2:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          csr_wen = 1'b0;
   logic [31:0]   csr_wdata = '0;

   // shadow of the allocator, indexed by side
   bit [63:0]     region_size;
   bit [63:0]     side_mark[2];
   bit [63:0]     side_perm[2];
   bit [63:0]     side_temp[2];
   bit [63:0]     side_peak[2];
   bit            perm_low;

   hunk_outcome_type outcome_q[$];
   temp_block_type   temp_blocks[$];

   int            src_idle_pct = 0;
   int            sink_stall_pct = 0;
   int            hold_requests = 0;
   int            hold_seen = 0;
   int            hold_left = 0;
   int            items_sent = 0;
   int            results_seen = 0;
   int            region_writes = 0;
   int            mismatch_count = 0;
   int            cycle_count = 0;

   two_ended_stack_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still due", cycle_count,
                  outcome_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response side: random stalls plus a long hold when one is requested
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   task automatic note_mismatch(string what, logic [31:0] due_v, logic [31:0] got_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("response %0d %s: expected %0h got %0h", results_seen, what, due_v, got_v);
   endtask

   task automatic check_field(string what, logic [31:0] due_v, logic [31:0] got_v);
      if (due_v !== got_v)
         note_mismatch(what, due_v, got_v);
   endtask

   always @(posedge clock) begin : rsp_check
      hunk_outcome_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (outcome_q.size() == 0) begin
            note_mismatch("unexpected transfer", 32'd0, rsp_tdata[31:0]);
         end else begin
            due = outcome_q.pop_front();
            check_field("status", 32'(due.status), 32'(rsp_tuser));
            check_field("grant_offset", due.grant_offset, rsp_tdata[31:0]);
            check_field("granted_size", due.granted_size, rsp_tdata[63:32]);
            check_field("bytes_left", due.bytes_left, rsp_tdata[95:64]);
            check_field("temp_clear", 32'(due.temp_clear), 32'(rsp_tdata[96]));
            check_field("mark_set", 32'(due.mark_set), 32'(rsp_tdata[97]));
            check_field("perm_on_low", 32'(due.perm_on_low), 32'(rsp_tdata[98]));
         end
      end
   end

   function automatic void clear_sides();
      for (int s = 0; s < 2; s++) begin
         side_mark[s] = '0;
         side_perm[s] = '0;
         side_temp[s] = '0;
         side_peak[s] = '0;
      end
      perm_low = 1'b1;
      temp_blocks.delete();
   endfunction

   // the temp side may take over permanent blocks when it is clear and has more peak slack
   function automatic void try_swap_sides();
      int     ts;
      int     ps;
      longint tslack;
      longint pslack;
      ts = perm_low ? HIGH_SIDE : LOW_SIDE;
      ps = perm_low ? LOW_SIDE : HIGH_SIDE;
      if (side_temp[ts] == side_perm[ts]) begin
         tslack = longint'(side_peak[ts]) - longint'(side_perm[ts]);
         pslack = longint'(side_peak[ps]) - longint'(side_perm[ps]);
         if (tslack > pslack)
            perm_low = !perm_low;
      end
   endfunction

   function automatic void advance_hunk(func_type fn, bit [31:0] size, place_type place,
                                        bit [31:0] boff, bit [31:0] bsize);
      hunk_outcome_type o;
      bit [63:0]     sz;
      bit [63:0]     hdr;
      bit [63:0]     goff;
      bit [63:0]     gsize;
      bit [63:0]     lo;
      bit [63:0]     hi;
      bit [63:0]     used;
      bit [63:0]     left;
      int            ps;
      int            ts;
      longint        want_offs;
      bit            ok;
      o.status = ST_OK;
      goff = '0;
      gsize = '0;
      case (fn)
         FN_ALLOC_PERM: begin
            if (size == 0) begin
               o.status = ST_ZERO_SIZE;
            end else begin
               if (place == PL_EITHER || place == PL_EITHER_ALT ||
                   (place == PL_LOW && !perm_low) || (place == PL_HIGH && perm_low))
                  try_swap_sides();
               sz = (({32'd0, size} + PERM_ALIGN - 1) / PERM_ALIGN) * PERM_ALIGN;
               if (side_temp[LOW_SIDE] + side_temp[HIGH_SIDE] + sz > region_size) begin
                  o.status = ST_NO_ROOM;
               end else begin
                  ps = perm_low ? LOW_SIDE : HIGH_SIDE;
                  if (perm_low) begin
                     goff = side_perm[ps];
                     side_perm[ps] += sz;
                  end else begin
                     side_perm[ps] += sz;
                     goff = region_size - side_perm[ps];
                  end
                  side_temp[ps] = side_perm[ps];
                  gsize = sz;
               end
            end
         end
         FN_ALLOC_TEMP: begin
            try_swap_sides();
            ps = perm_low ? LOW_SIDE : HIGH_SIDE;
            ts = perm_low ? HIGH_SIDE : LOW_SIDE;
            sz = (({32'd0, size} + TEMP_ALIGN - 1) / TEMP_ALIGN) * TEMP_ALIGN + HEADER_BYTES;
            if (side_temp[ts] + side_perm[ps] + sz > region_size) begin
               o.status = ST_NO_ROOM;
            end else begin
               if (!perm_low) begin
                  hdr = side_temp[ts];
                  side_temp[ts] += sz;
               end else begin
                  side_temp[ts] += sz;
                  hdr = region_size - side_temp[ts];
               end
               if (side_temp[ts] > side_peak[ts])
                  side_peak[ts] = side_temp[ts];
               goff = hdr + HEADER_BYTES;
               gsize = sz;
               temp_blocks.push_back('{offs: goff[31:0], bytes: gsize[31:0]});
            end
         end
         FN_FREE_TEMP: begin
            ts = perm_low ? HIGH_SIDE : LOW_SIDE;
            ok = (side_temp[ts] >= side_perm[ts]) &&
                 ({32'd0, bsize} <= side_temp[ts] - side_perm[ts]);
            if (ok) begin
               if (!perm_low)
                  want_offs = longint'(side_temp[ts]) - longint'({32'd0, bsize}) +
                              longint'(HEADER_BYTES);
               else
                  want_offs = longint'(region_size) - longint'(side_temp[ts]) +
                              longint'(HEADER_BYTES);
               ok = (want_offs == longint'({32'd0, boff}));
            end
            if (ok) begin
               side_temp[ts] -= {32'd0, bsize};
               if (temp_blocks.size() != 0)
                  void'(temp_blocks.pop_back());
            end else begin
               o.status = ST_NOT_LAST;
            end
         end
         FN_CLEAR_TEMP: begin
            ts = perm_low ? HIGH_SIDE : LOW_SIDE;
            side_temp[ts] = side_perm[ts];
            temp_blocks.delete();
         end
         FN_SET_MARK: begin
            side_mark[LOW_SIDE] = side_perm[LOW_SIDE];
            side_mark[HIGH_SIDE] = side_perm[HIGH_SIDE];
         end
         FN_CLEAR_MARK: begin
            for (int s = 0; s < 2; s++) begin
               side_perm[s] = side_mark[s];
               side_temp[s] = side_mark[s];
            end
            temp_blocks.delete();
         end
         FN_CLEAR_ALL: clear_sides();
         default: ;
      endcase
      lo = (side_perm[LOW_SIDE] > side_temp[LOW_SIDE]) ? side_perm[LOW_SIDE]
                                                       : side_temp[LOW_SIDE];
      hi = (side_perm[HIGH_SIDE] > side_temp[HIGH_SIDE]) ? side_perm[HIGH_SIDE]
                                                         : side_temp[HIGH_SIDE];
      used = lo + hi;
      left = (used > region_size) ? 64'd0 : region_size - used;
      ts = perm_low ? HIGH_SIDE : LOW_SIDE;
      o.grant_offset = goff[31:0];
      o.granted_size = gsize[31:0];
      o.bytes_left = left[31:0];
      o.temp_clear = (side_temp[ts] == side_perm[ts]);
      o.mark_set = (side_mark[LOW_SIDE] != 0) || (side_mark[HIGH_SIDE] != 0);
      o.perm_on_low = perm_low;
      outcome_q.push_back(o);
   endfunction

   task automatic send_req(func_type fn, bit [31:0] size, place_type place,
                           bit [31:0] boff, bit [31:0] bsize);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= {6'd0, bsize, boff, place, size};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_hunk(fn, size, place, boff, bsize);
      items_sent++;
   endtask

   task automatic send_free(bit [31:0] boff, bit [31:0] bsize);
      send_req(FN_FREE_TEMP, $urandom, place_type'($urandom_range(3)), boff, bsize);
   endtask

   task automatic send_simple(func_type fn, bit [31:0] size, place_type place);
      send_req(fn, size, place, $urandom, $urandom);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_region_size(bit [31:0] value);
      drain_results();
      csr_wdata <= value;
      csr_wen <= 1'b1;
      @(posedge clock);
      csr_wen <= 1'b0;
      region_size = {32'd0, value};
      temp_blocks.delete();
      region_writes++;
      @(posedge clock);
   endtask

   task automatic set_idle(int src_pct, int sink_pct);
      src_idle_pct = src_pct;
      sink_stall_pct = sink_pct;
   endtask

   task automatic send_random_op();
      int             pick;
      bit [31:0]      size;
      temp_block_type blk;
      pick = $urandom_range(99);
      if (pick < 28) begin
         size = ($urandom_range(19) == 0) ? $urandom : $urandom_range(300);
         send_simple(FN_ALLOC_TEMP, size, place_type'($urandom_range(3)));
      end else if (pick < 48) begin
         case ($urandom_range(19))
            0: size = 32'd0;
            1: size = $urandom;
            default: size = $urandom_range(1, 500);
         endcase
         send_simple(FN_ALLOC_PERM, size, place_type'($urandom_range(3)));
      end else if (pick < 70) begin
         if (temp_blocks.size() != 0 && $urandom_range(3) != 0) begin
            blk = temp_blocks[temp_blocks.size() - 1];
            send_free(blk.offs, blk.bytes);
         end else if (temp_blocks.size() != 0 && $urandom_range(1) == 0) begin
            // a real block, possibly not on top, with its offset or size off by one alignment step
            blk = temp_blocks[$urandom_range(temp_blocks.size() - 1)];
            if ($urandom_range(1) == 0)
               send_free(blk.offs + TEMP_ALIGN, blk.bytes);
            else
               send_free(blk.offs, blk.bytes + TEMP_ALIGN);
         end else begin
            send_free($urandom, $urandom);
         end
      end else if (pick < 77) begin
         send_simple(FN_CLEAR_TEMP, $urandom, place_type'($urandom_range(3)));
      end else if (pick < 84) begin
         send_simple(FN_SET_MARK, $urandom, place_type'($urandom_range(3)));
      end else if (pick < 90) begin
         send_simple(FN_CLEAR_MARK, $urandom, place_type'($urandom_range(3)));
      end else if (pick < 94) begin
         send_simple(FN_CLEAR_ALL, $urandom, place_type'($urandom_range(3)));
      end else begin
         send_req(func_type'($urandom_range(7)), $urandom, place_type'($urandom_range(3)),
                  $urandom, $urandom);
      end
   endtask

   task automatic check_directed_ops();
      send_simple(FN_NOP, $urandom, PL_EITHER);
      send_simple(FN_ALLOC_PERM, 32'd0, PL_EITHER);
      send_simple(FN_ALLOC_PERM, 32'd1, PL_LOW);
      send_simple(FN_ALLOC_TEMP, 32'd0, PL_EITHER);
      send_simple(FN_ALLOC_TEMP, 32'd13, PL_HIGH);
      // bottom block is not on top of the temp stack
      send_free(temp_blocks[0].offs, temp_blocks[0].bytes);
      send_free(temp_blocks[temp_blocks.size() - 1].offs, 32'hFFFF_FFFF);
      send_free(temp_blocks[temp_blocks.size() - 1].offs,
                temp_blocks[temp_blocks.size() - 1].bytes);
      send_simple(FN_CLEAR_TEMP, $urandom, PL_EITHER);
      send_simple(FN_SET_MARK, $urandom, PL_EITHER);
      // low side is clear with peak slack while the high side slack turns negative
      send_simple(FN_ALLOC_PERM, 32'd100, PL_HIGH);
      send_simple(FN_ALLOC_PERM, 32'd64, PL_LOW);
      send_simple(FN_ALLOC_PERM, 32'd200, PL_EITHER_ALT);
      send_simple(FN_ALLOC_TEMP, 32'hFFFF_FFFF, PL_EITHER);
      send_simple(FN_ALLOC_PERM, 32'hFFFF_FFFF, PL_EITHER);
      send_simple(FN_ALLOC_TEMP, 32'd40, PL_EITHER);
      send_simple(FN_ALLOC_TEMP, 32'd7, PL_EITHER);
      send_simple(FN_CLEAR_MARK, $urandom, PL_EITHER);
      send_simple(FN_ALLOC_TEMP, 32'd24, PL_EITHER);
      send_simple(FN_CLEAR_ALL, $urandom, PL_EITHER);
      send_simple(FN_ALLOC_PERM, 32'd65, PL_EITHER);
   endtask

   task automatic check_region_size_extremes();
      set_region_size(32'd0);
      send_simple(FN_ALLOC_PERM, 32'd1, PL_EITHER);
      send_simple(FN_ALLOC_TEMP, 32'd0, PL_EITHER);
      send_simple(FN_NOP, $urandom, PL_EITHER);
      set_region_size(32'hFFFF_FFFF);
      send_simple(FN_CLEAR_ALL, $urandom, PL_EITHER);
      send_simple(FN_ALLOC_PERM, 32'hFFFF_FFC0, PL_LOW);
      send_simple(FN_ALLOC_TEMP, 32'd0, PL_EITHER);
      send_simple(FN_ALLOC_TEMP, 32'd0, PL_EITHER);
      // shrink below what is in use, bytes left has to saturate
      set_region_size(32'd256);
      send_simple(FN_SET_MARK, $urandom, PL_EITHER);
      send_free(32'hFFFF_FFFF, 32'd16);
      set_region_size(32'd0);
      send_free(32'd0, 32'd16);
      send_simple(FN_CLEAR_ALL, $urandom, PL_EITHER);
      set_region_size(HUNK_RESET);
   endtask

   task automatic check_response_backpressure();
      set_region_size(32'd4096);
      set_idle(0, 0);
      hold_requests <= hold_requests + 1;
      repeat (40) send_random_op();
      drain_results();
   endtask

   task automatic check_random_traffic();
      int src_pct[4]  = '{0, 65, 0, 29};
      int sink_pct[4] = '{0, 0, 65, 29};
      for (int ph = 0; ph < 4; ph++) begin
         set_region_size($urandom_range(1024, 16384));
         set_idle(src_pct[ph], sink_pct[ph]);
         repeat (75) send_random_op();
      end
      set_region_size(32'hFFFF_FFFF);
      set_idle(29, 29);
      repeat (30) send_random_op();
      drain_results();
   endtask

   initial begin
      clear_sides();
      region_size = {32'd0, HUNK_RESET};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_directed_ops();
      check_region_size_extremes();
      check_response_backpressure();
      check_random_traffic();
      drain_results();
      repeat (10) @(posedge clock);
      $display("ran %0d requests and checked %0d responses, %0d region size writes",
               items_sent, results_seen, region_writes);
      $display("directed ops, region extremes, a long response hold and four idle mixes");
      if (mismatch_count == 0 && outcome_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count, outcome_q.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
